// ===== rtl/dqds_pkg.sv =====
// dual quadrature decoder speed: shared types, constants and step decode
// no dependencies; used by dqds_divmul and dual_quadrature_decoder_speed_core
`default_nettype none

package dqds_pkg;

  localparam int SCALE_W   = 32;
  localparam int ELAPSED_W = 24;
  localparam int POS_W     = 32;
  localparam int SPEED_W   = 16;
  localparam int QUOT_W    = 15;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd1218557;

  localparam logic [SPEED_W-1:0] SPEED_POS_LIMIT = 16'h7FFF;
  localparam logic [SPEED_W-1:0] SPEED_NEG_LIMIT = 16'h8000;

  // transition codes {last_a, last_b, cur_a, cur_b}
  localparam logic [3:0] TR_FWD_0 = 4'b0001;
  localparam logic [3:0] TR_FWD_1 = 4'b0111;
  localparam logic [3:0] TR_FWD_2 = 4'b1110;
  localparam logic [3:0] TR_FWD_3 = 4'b1000;
  localparam logic [3:0] TR_REV_0 = 4'b0010;
  localparam logic [3:0] TR_REV_1 = 4'b0100;
  localparam logic [3:0] TR_REV_2 = 4'b1011;
  localparam logic [3:0] TR_REV_3 = 4'b1101;

  typedef enum logic [1:0] {
    DIR_NONE,
    DIR_FWD,
    DIR_REV
  } dir_e;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

  function automatic dir_e step_dir(input logic [1:0] last, input logic [1:0] cur);
    dir_e dir;
    case ({last, cur})
      TR_FWD_0, TR_FWD_1, TR_FWD_2, TR_FWD_3: dir = DIR_FWD;
      TR_REV_0, TR_REV_1, TR_REV_2, TR_REV_3: dir = DIR_REV;
      default:                                dir = DIR_NONE;
    endcase
    return dir;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dqds_divmul.sv =====
// shared sequential unit: shift-add multiply of magnitude by scale, then
// restoring division by elapsed time with saturation flag; uses dqds_pkg
`default_nettype none

module dqds_divmul #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [COUNT_WIDTH-1:0]         mag_i,
  input  wire logic [dqds_pkg::SCALE_W-1:0]   scale_i,
  input  wire logic [dqds_pkg::ELAPSED_W-1:0] div_i,
  output dqds_pkg::div_res_t                  res_o
);

  localparam int ProdW = COUNT_WIDTH + dqds_pkg::SCALE_W;
  localparam int CntW  = $clog2(ProdW + 1);
  localparam int RemW  = dqds_pkg::ELAPSED_W;
  localparam int QW    = dqds_pkg::QUOT_W;

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_DIV  = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   done_q, done_d;
  logic [ProdW-1:0]       prod_q, prod_d;
  logic [COUNT_WIDTH-1:0] mag_q, mag_d;
  logic [RemW-1:0]        rem_q, rem_d;
  logic [QW:0]            quot_q, quot_d;
  logic                   ovf_q, ovf_d;

  logic [RemW:0]          rem_shift;
  logic [RemW:0]          rem_diff;
  logic                   rem_ge;
  logic [ProdW-1:0]       addend;

  assign rem_shift = {rem_q, prod_q[ProdW-1]};
  assign rem_diff  = rem_shift - {1'b0, div_i};
  assign rem_ge    = rem_shift >= {1'b0, div_i};
  assign addend    = mag_q[COUNT_WIDTH-1] ? ProdW'(scale_i) : '0;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    prod_d  = prod_q;
    mag_d   = mag_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    ovf_d   = ovf_q;
    case (state_q)
      U_IDLE: begin
        if (start_i) begin
          state_d = U_MUL;
          cnt_d   = CntW'(COUNT_WIDTH);
          prod_d  = '0;
          mag_d   = mag_i;
          rem_d   = '0;
          quot_d  = '0;
          ovf_d   = 1'b0;
        end
      end
      U_MUL: begin
        prod_d = {prod_q[ProdW-2:0], 1'b0} + addend;
        mag_d  = {mag_q[COUNT_WIDTH-2:0], 1'b0};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          state_d = U_DIV;
          cnt_d   = CntW'(ProdW);
        end
      end
      U_DIV: begin
        rem_d  = rem_ge ? rem_diff[RemW-1:0] : rem_shift[RemW-1:0];
        prod_d = {prod_q[ProdW-2:0], 1'b0};
        quot_d = {quot_q[QW-1:0], rem_ge};
        ovf_d  = ovf_q | quot_q[QW];
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          state_d = U_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    mag_q  <= mag_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    ovf_q  <= ovf_d;
  end

  assign res_o.done = done_q;
  assign res_o.sat  = ovf_q | quot_q[QW];
  assign res_o.quot = quot_q[QW-1:0];

  a_done_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) == U_DIV)
    else $error("done without a division pass");

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == U_IDLE)
    else $error("start while busy");

  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != U_IDLE |-> cnt_q != '0)
    else $error("step counter empty while busy");

endmodule

`default_nettype wire

// ===== rtl/dual_quadrature_decoder_speed_core.sv =====
// dual quadrature decoder with angular speed, top level
// uses dqds_pkg and the shared multiply/divide unit dqds_divmul
//
// input channel (in_valid_i / in_stall_o): one request per pin sample or speed
// tick. a sample (mode_i low) is taken and updates both counts; it
// gives no result. a tick (mode_i high) gives one result on the output channel
// (out_valid_o / out_stall_i) with both positions and both Q7.8 speeds.
// a tick runs both speeds one after the other through one shift-add multiplier
// and one restoring divider: per encoder COUNT_WIDTH multiply steps and
// COUNT_WIDTH+32 divide steps, each pass begun from its own start state, and
// the result then goes to the output register. in_stall_o is high from the
// tick until its result is in the output register; samples flow at one per
// cycle otherwise.
// a finished result waits in the output register while out_stall_i is high;
// samples are still taken then, and a following tick computes but holds its
// result until the register frees up.
// reset clears the counts, previous counts and pin history to zero and loads
// speed_scale with its default; cfg_we_i writes speed_scale.
`default_nettype none

module dual_quadrature_decoder_speed_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [dqds_pkg::SCALE_W-1:0]          cfg_wdata_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic                                  mode_i,
  input  wire logic                                  right_a_i,
  input  wire logic                                  right_b_i,
  input  wire logic                                  left_a_i,
  input  wire logic                                  left_b_i,
  input  wire logic [dqds_pkg::ELAPSED_W-1:0]        elapsed_us_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed [dqds_pkg::POS_W-1:0]          right_position_o,
  output logic signed [dqds_pkg::POS_W-1:0]          left_position_o,
  output logic signed [dqds_pkg::SPEED_W-1:0]        right_vel_o,
  output logic signed [dqds_pkg::SPEED_W-1:0]        left_vel_o
);

  localparam int CW = COUNT_WIDTH;
  localparam int SW = dqds_pkg::SPEED_W;
  localparam int PW = dqds_pkg::POS_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RSTART = 3'd1;
  localparam logic [2:0] ST_RWAIT  = 3'd2;
  localparam logic [2:0] ST_LSTART = 3'd3;
  localparam logic [2:0] ST_LWAIT  = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  logic [2:0]                       st_q, st_d;
  logic [dqds_pkg::SCALE_W-1:0]     scale_q;
  logic [1:0]                       right_pins_q, left_pins_q;
  logic [CW-1:0]                    right_cnt_q, left_cnt_q;
  logic [CW-1:0]                    right_prev_q, left_prev_q;
  logic [CW-1:0]                    right_delta_q, left_delta_q;
  logic [dqds_pkg::ELAPSED_W-1:0]   elapsed_q;
  logic [SW-1:0]                    right_vel_q, left_vel_q;
  logic                             out_valid_q;
  logic [PW-1:0]                    out_rpos_q, out_lpos_q;
  logic [SW-1:0]                    out_rspd_q, out_lspd_q;

  logic                             in_acc;
  logic                             out_free;
  logic [1:0]                       right_cur, left_cur;
  dqds_pkg::dir_e                   right_dir, left_dir;
  logic [CW-1:0]                    sel_delta;
  logic                             sel_neg;
  logic [CW-1:0]                    sel_mag;
  logic                             unit_start;
  dqds_pkg::div_res_t               unit_res;
  logic [SW-1:0]                    q_mag;
  logic [SW-1:0]                    side_speed;
  logic signed [63:0]               rpos_ext, lpos_ext;

  assign in_stall_o = (st_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign right_cur = {right_a_i, right_b_i};
  assign left_cur  = {left_a_i, left_b_i};
  assign right_dir = dqds_pkg::step_dir(right_pins_q, right_cur);
  assign left_dir  = dqds_pkg::step_dir(left_pins_q, left_cur);

  // side being worked on by the shared unit
  assign sel_delta  = (st_q == ST_RSTART || st_q == ST_RWAIT) ? right_delta_q : left_delta_q;
  assign sel_neg    = sel_delta[CW-1];
  assign sel_mag    = sel_neg ? (~sel_delta + 1'b1) : sel_delta;
  assign unit_start = (st_q == ST_RSTART) || (st_q == ST_LSTART);

  dqds_divmul #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_divmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(unit_start),
    .mag_i  (sel_mag),
    .scale_i(scale_q),
    .div_i  (elapsed_q),
    .res_o  (unit_res)
  );

  always_comb begin
    if (unit_res.sat) begin
      q_mag = sel_neg ? dqds_pkg::SPEED_NEG_LIMIT : dqds_pkg::SPEED_POS_LIMIT;
    end else begin
      q_mag = {1'b0, unit_res.quot};
    end
    if (sel_delta == '0) begin
      side_speed = '0;
    end else if (sel_neg) begin
      side_speed = ~q_mag + 1'b1;
    end else begin
      side_speed = q_mag;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_acc && mode_i) begin
          st_d = ST_RSTART;
        end
      end
      ST_RSTART: st_d = ST_RWAIT;
      ST_RWAIT: begin
        if (unit_res.done) begin
          st_d = ST_LSTART;
        end
      end
      ST_LSTART: st_d = ST_LWAIT;
      ST_LWAIT: begin
        if (unit_res.done) begin
          st_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      scale_q      <= dqds_pkg::SCALE_RESET;
      right_pins_q <= '0;
      left_pins_q  <= '0;
      right_cnt_q  <= '0;
      left_cnt_q   <= '0;
      right_prev_q <= '0;
      left_prev_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      if (in_acc && !mode_i) begin
        right_pins_q <= right_cur;
        left_pins_q  <= left_cur;
        case (right_dir)
          dqds_pkg::DIR_FWD: right_cnt_q <= right_cnt_q + 1'b1;
          dqds_pkg::DIR_REV: right_cnt_q <= right_cnt_q - 1'b1;
          default:           right_cnt_q <= right_cnt_q;
        endcase
        case (left_dir)
          dqds_pkg::DIR_FWD: left_cnt_q <= left_cnt_q - 1'b1;
          dqds_pkg::DIR_REV: left_cnt_q <= left_cnt_q + 1'b1;
          default:           left_cnt_q <= left_cnt_q;
        endcase
      end
      if (in_acc && mode_i) begin
        right_prev_q <= right_cnt_q;
        left_prev_q  <= left_cnt_q;
      end
      if (st_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rpos_ext = 64'(signed'(right_cnt_q));
  assign lpos_ext = 64'(signed'(left_cnt_q));

  always_ff @(posedge clk_i) begin
    if (in_acc && mode_i) begin
      right_delta_q <= right_cnt_q - right_prev_q;
      left_delta_q  <= left_cnt_q - left_prev_q;
      elapsed_q     <= elapsed_us_i;
    end
    if (st_q == ST_RWAIT && unit_res.done) begin
      right_vel_q <= side_speed;
    end
    if (st_q == ST_LWAIT && unit_res.done) begin
      left_vel_q <= side_speed;
    end
    if (st_q == ST_OUT && out_free) begin
      out_rpos_q <= rpos_ext[PW-1:0];
      out_lpos_q <= lpos_ext[PW-1:0];
      out_rspd_q <= right_vel_q;
      out_lspd_q <= left_vel_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign right_position_o = signed'(out_rpos_q);
  assign left_position_o  = signed'(out_lpos_q);
  assign right_vel_o      = signed'(out_rspd_q);
  assign left_vel_o       = signed'(out_lspd_q);

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_res.done |-> (st_q == ST_RWAIT || st_q == ST_LWAIT))
    else $error("unit result outside a wait state");

  a_counts_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != ST_IDLE |=> $stable(right_cnt_q) && $stable(left_cnt_q))
    else $error("count moved during a speed request");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q) == ST_OUT)
    else $error("result raised outside the output state");

endmodule

`default_nettype wire
